>>> sv/g2l_pkg.sv
`default_nettype none
package g2l_pkg;

  localparam int TABLE_YEARS = 73;
  localparam int BASE_YEAR   = 1968;

  localparam int YEAR_W = 11;
  localparam int MON_W  = 4;
  localparam int DAY_W  = 5;
  localparam int IDX_W  = $clog2(TABLE_YEARS + 1);
  localparam int OFF_W  = 11;
  localparam int MASK_W = 13;
  localparam int N_W    = 4;

  typedef struct packed {
    logic [YEAR_W-1:0] greg_year;
    logic [MON_W-1:0]  greg_month;
    logic [DAY_W-1:0]  greg_day;
  } g2l_in_t;

  typedef struct packed {
    logic [YEAR_W-1:0] lunar_year;
    logic [MON_W-1:0]  lunar_month;
    logic              leap_month;
    logic [DAY_W-1:0]  lunar_day;
    logic              in_range;
  } g2l_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DOY,
    ST_NEWYR,
    ST_LOAD,
    ST_WALK,
    ST_RESULT
  } g2l_state_t;

  // gregorian date of lunar new year, coded as month*100+day
  localparam logic [7:0] NY_CODE [TABLE_YEARS] = '{
    8'd130, 8'd217, 8'd206,
    8'd127, 8'd215, 8'd203, 8'd123, 8'd211, 8'd131, 8'd218, 8'd207, 8'd128, 8'd216,
    8'd205, 8'd125, 8'd213, 8'd202, 8'd220, 8'd209, 8'd219, 8'd217, 8'd206, 8'd127,
    8'd215, 8'd204, 8'd123, 8'd210, 8'd131, 8'd219, 8'd207, 8'd128, 8'd216, 8'd205,
    8'd124, 8'd212, 8'd201, 8'd122, 8'd209, 8'd129, 8'd218, 8'd207, 8'd126, 8'd214,
    8'd203, 8'd123, 8'd210, 8'd131, 8'd219, 8'd208, 8'd128, 8'd216, 8'd205, 8'd125,
    8'd212, 8'd201, 8'd122, 8'd210, 8'd129, 8'd217, 8'd206, 8'd126, 8'd213, 8'd203,
    8'd123, 8'd211, 8'd131, 8'd219, 8'd208, 8'd128, 8'd215, 8'd204, 8'd124, 8'd212
  };

  // month lengths (1 = 30 days), leap month number in bits 19:16
  localparam logic [19:0] MONTH_MASK [TABLE_YEARS] = '{
    20'd461653, 20'd1386, 20'd2413,
    20'd330077, 20'd1197, 20'd2637, 20'd268877, 20'd3365, 20'd531109, 20'd2900,
    20'd2922, 20'd398042, 20'd2395,
    20'd1179, 20'd267415, 20'd2635, 20'd661067, 20'd1701, 20'd1748, 20'd398772,
    20'd2742, 20'd2391, 20'd330031,
    20'd1175, 20'd1611, 20'd200010, 20'd3749, 20'd527717, 20'd1452, 20'd2742,
    20'd332397, 20'd2350, 20'd3222,
    20'd268949, 20'd3402, 20'd3493, 20'd133973, 20'd1386, 20'd464219, 20'd605,
    20'd2349, 20'd334123, 20'd2709,
    20'd2890, 20'd267946, 20'd2773, 20'd592565, 20'd1210, 20'd2651, 20'd395863,
    20'd1323, 20'd2707, 20'd265877,
    20'd1706, 20'd2773, 20'd133557, 20'd1206, 20'd398510, 20'd2638, 20'd3366,
    20'd335142, 20'd3411, 20'd1450,
    20'd200042, 20'd2413, 20'd723293, 20'd1197, 20'd2637, 20'd399947, 20'd3365,
    20'd3410, 20'd334676, 20'd2906
  };

  localparam logic [8:0] DAYS_BEFORE [12] = '{
    9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181, 9'd212, 9'd243, 9'd273,
    9'd304, 9'd334
  };

  function automatic logic [1:0] ny_month(input logic [IDX_W-1:0] idx);
    return (NY_CODE[idx] >= 8'd200) ? 2'd2 : 2'd1;
  endfunction

  function automatic logic [DAY_W-1:0] ny_day(input logic [IDX_W-1:0] idx);
    logic [7:0] code;
    begin
      code = NY_CODE[idx];
      return (code >= 8'd200) ? DAY_W'(code - 8'd200) : DAY_W'(code - 8'd100);
    end
  endfunction

  // day of year as 31*(month-1)+day
  function automatic logic [5:0] ny_doy(input logic [IDX_W-1:0] idx);
    logic [5:0] d;
    begin
      d = 6'(ny_day(idx));
      return (ny_month(idx) == 2'd2) ? d + 6'd31 : d;
    end
  endfunction

endpackage
`default_nettype wire

>>> sv/g2l_core.sv
`default_nettype none
module g2l_core (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output      logic               in_ready,
  input  wire g2l_pkg::g2l_in_t   in_data,
  output      logic               res_valid,
  input  wire logic               res_ready,
  output      g2l_pkg::g2l_out_t  res_data
);
  import g2l_pkg::*;

  localparam logic [YEAR_W-1:0] YEAR_LO = YEAR_W'(BASE_YEAR + 1);
  localparam logic [YEAR_W-1:0] YEAR_HI = YEAR_W'(BASE_YEAR + TABLE_YEARS - 1);
  localparam logic [IDX_W-1:0]  IDX_LAST = IDX_W'(TABLE_YEARS - 1);

  g2l_state_t               state_r, state_nxt;
  g2l_in_t                  in_r, in_nxt;
  g2l_out_t                 res_r, res_nxt;
  logic [IDX_W-1:0]         idx_r, idx_nxt;
  logic                     before_r, before_nxt;
  logic signed [OFF_W-1:0]  off_r, off_nxt;
  logic [MASK_W-1:0]        mask_r, mask_nxt;
  logic [3:0]               lm_r, lm_nxt;
  logic [N_W-1:0]           k_r, k_nxt;
  logic [N_W-1:0]           n_r, n_nxt;

  logic [MON_W-1:0]         m_sat;
  logic [IDX_W-1:0]         idx_in;
  logic [1:0]               fm;
  logic [DAY_W-1:0]         fd;
  logic                     is_before;
  logic [19:0]              mask_rd;
  logic signed [OFF_W-1:0]  len;
  logic [N_W-1:0]           pos;
  logic [4:0]               lm1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    in_r     <= in_nxt;
    res_r    <= res_nxt;
    idx_r    <= idx_nxt;
    before_r <= before_nxt;
    off_r    <= off_nxt;
    mask_r   <= mask_nxt;
    lm_r     <= lm_nxt;
    k_r      <= k_nxt;
    n_r      <= n_nxt;
  end

  always_comb begin
    state_nxt  = state_r;
    in_nxt     = in_r;
    res_nxt    = res_r;
    idx_nxt    = idx_r;
    before_nxt = before_r;
    off_nxt    = off_r;
    mask_nxt   = mask_r;
    lm_nxt     = lm_r;
    k_nxt      = k_r;
    n_nxt      = n_r;
    in_ready   = 1'b0;
    res_valid  = 1'b0;

    // month clamp and new year lookup for the latched date
    if (in_r.greg_month == '0) begin
      m_sat = MON_W'(1);
    end else if (in_r.greg_month > MON_W'(12)) begin
      m_sat = MON_W'(12);
    end else begin
      m_sat = in_r.greg_month;
    end
    idx_in    = IDX_W'(in_r.greg_year - YEAR_W'(BASE_YEAR));
    fm        = ny_month(idx_in);
    fd        = ny_day(idx_in);
    is_before = (m_sat < MON_W'(fm)) || ((m_sat == MON_W'(fm)) && (in_r.greg_day < fd));

    mask_rd = MONTH_MASK[idx_r];
    len     = OFF_W'(29) + OFF_W'(mask_r[n_r]);
    pos     = k_r - n_r + N_W'(1);
    lm1     = {1'b0, lm_r} + 5'd1;

    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          in_nxt = in_data;
          if ((in_data.greg_year < YEAR_LO) || (in_data.greg_year > YEAR_HI)) begin
            res_nxt   = '0;
            state_nxt = ST_RESULT;
          end else begin
            state_nxt = ST_DOY;
          end
        end
      end
      ST_DOY: begin
        off_nxt = OFF_W'(in_r.greg_day) + OFF_W'(DAYS_BEFORE[m_sat - MON_W'(1)]) + OFF_W'(1)
                  + OFF_W'((in_r.greg_year[1:0] == 2'd0) && (m_sat > MON_W'(2)));
        before_nxt = is_before;
        idx_nxt    = is_before ? idx_in - IDX_W'(1) : idx_in;
        state_nxt  = ST_NEWYR;
      end
      ST_NEWYR: begin
        // offset from the lunar new year that precedes the date
        off_nxt = off_r - OFF_W'(ny_doy(idx_r))
                  + (before_r ? OFF_W'(365) + OFF_W'(in_r.greg_year[1:0] == 2'd1)
                              : OFF_W'(0));
        state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        mask_nxt  = mask_rd[MASK_W-1:0];
        lm_nxt    = mask_rd[19:16];
        k_nxt     = (mask_rd < 20'd4095) ? N_W'(11) : N_W'(12);
        n_nxt     = (mask_rd < 20'd4095) ? N_W'(11) : N_W'(12);
        state_nxt = ST_WALK;
      end
      ST_WALK: begin
        if (off_r <= len) begin
          res_nxt.lunar_year  = YEAR_W'(BASE_YEAR) + YEAR_W'(idx_r);
          res_nxt.lunar_month = pos;
          res_nxt.leap_month  = 1'b0;
          res_nxt.lunar_day   = off_r[DAY_W-1:0];
          res_nxt.in_range    = 1'b1;
          if (k_r == N_W'(12)) begin
            if ({1'b0, pos} == lm1) begin
              res_nxt.lunar_month = lm_r;
              res_nxt.leap_month  = 1'b1;
            end else if ({1'b0, pos} > lm1) begin
              res_nxt.lunar_month = pos - N_W'(1);
            end
          end
          state_nxt = ST_RESULT;
        end else begin
          off_nxt = off_r - len;
          if (n_r == '0) begin
            if (idx_r == IDX_LAST) begin
              res_nxt   = '0;
              state_nxt = ST_RESULT;
            end else begin
              idx_nxt   = idx_r + IDX_W'(1);
              state_nxt = ST_LOAD;
            end
          end else begin
            n_nxt = n_r - N_W'(1);
          end
        end
      end
      ST_RESULT: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign res_data = res_r;

endmodule
`default_nettype wire

>>> sv/gregorian_to_lunar_date_top.sv
// after an input transfer: setup states for day of year, new year offset and table load,
// then one lunar month tested per cycle, then the result state and the output register;
// a year out of range goes straight to the result state. One conversion at a time: the next
// input is taken only after the result leaves; the output register frees the sequencer early
// reset: synchronous active-low rst_n clears sequencer state and out_valid
`default_nettype none
module gregorian_to_lunar_date_top (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output      logic               in_ready,
  input  wire g2l_pkg::g2l_in_t   in_data,
  output      logic               out_valid,
  input  wire logic               out_ready,
  output      g2l_pkg::g2l_out_t  out_data
);
  import g2l_pkg::*;

  logic      res_valid;
  logic      res_ready;
  g2l_out_t  res_data;

  logic      out_valid_r;
  g2l_out_t  out_data_r;

  // shared month walker and its sequencer
  g2l_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data)
  );

  // output register: takes a result whenever empty or being drained
  assign res_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_data_r <= res_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTH
  // a converted date always lands on a real lunar day and month
  a_day_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.in_range) |->
      (out_data.lunar_day >= DAY_W'(1)) && (out_data.lunar_day <= DAY_W'(30)) &&
      (out_data.lunar_month >= MON_W'(1)) && (out_data.lunar_month <= MON_W'(12)))
    else $error("lunar day or month out of range");

  // a rejected date carries all-zero fields
  a_zero_out: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.in_range) |->
      (out_data.lunar_year == '0) && (out_data.lunar_month == '0) &&
      (out_data.lunar_day == '0) && !out_data.leap_month)
    else $error("out-of-range result with nonzero fields");

  // the sequencer never takes a new date in the cycle after one was taken
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken while conversion in progress");
`endif

endmodule
`default_nettype wire

>>> sim/gregorian_to_lunar_date_top_tb.sv
`timescale 1ns / 100ps

module gregorian_to_lunar_date_top_tb;
  import g2l_pkg::*;

  // one directed row: the date, and the result when it is typed in by hand
  typedef struct packed {
    logic               typed;
    g2l_pkg::g2l_out_t  want;
    g2l_pkg::g2l_in_t   date;
  } date_case_t;

  localparam int ROM_FIRST_YEAR = 1968;
  localparam int ROM_YEARS      = 73;
  localparam int DIRECTED_N     = 24;
  localparam int LONG_HOLD      = 300;

  // lunar new year per year from 1968, coded month*100+day
  localparam int unsigned NY_MMDD [ROM_YEARS] = '{
    130, 217, 206,
    127, 215, 203, 123, 211, 131, 218, 207, 128, 216,
    205, 125, 213, 202, 220, 209, 219, 217, 206, 127,
    215, 204, 123, 210, 131, 219, 207, 128, 216, 205,
    124, 212, 201, 122, 209, 129, 218, 207, 126, 214,
    203, 123, 210, 131, 219, 208, 128, 216, 205, 125,
    212, 201, 122, 210, 129, 217, 206, 126, 213, 203,
    123, 211, 131, 219, 208, 128, 215, 204, 124, 212
  };

  // month lengths, 1 = 30 days, first month in the top used bit;
  // number of the repeated month from bit 16 up
  localparam int unsigned MONTH_BITS [ROM_YEARS] = '{
    461653, 1386, 2413,
    330077, 1197, 2637, 268877, 3365, 531109, 2900, 2922, 398042, 2395,
    1179, 267415, 2635, 661067, 1701, 1748, 398772, 2742, 2391, 330031,
    1175, 1611, 200010, 3749, 527717, 1452, 2742, 332397, 2350, 3222,
    268949, 3402, 3493, 133973, 1386, 464219, 605, 2349, 334123, 2709,
    2890, 267946, 2773, 592565, 1210, 2651, 395863, 1323, 2707, 265877,
    1706, 2773, 133557, 1206, 398510, 2638, 3366, 335142, 3411, 1450,
    200042, 2413, 723293, 1197, 2637, 399947, 3365, 3410, 334676, 2906
  };

  localparam int DAYS_BEFORE_MON [12] = '{
    0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334
  };

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  g2l_pkg::g2l_in_t   in_data;
  logic               out_valid;
  logic               out_ready;
  g2l_pkg::g2l_out_t  out_data;

  // lunar dates still owed by the block, oldest first
  g2l_pkg::g2l_out_t  lunar_due_q [$];

  int mismatches   = 0;
  int results_seen = 0;
  int send_idle_pct;
  int rcv_idle_pct;
  bit hold_armed   = 1'b0;
  bit hold_done    = 1'b0;
  int hold_left    = 0;

  gregorian_to_lunar_date_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // predicted lunar date for one gregorian date
  function automatic g2l_pkg::g2l_out_t lunar_date_of(input g2l_pkg::g2l_in_t g);
    g2l_pkg::g2l_out_t r;
    int          yr, mo, dy, idx, off, k, n, span, pos, mon, lm;
    int unsigned bits;
    bit          early, found;
    r = '0;
    yr = int'(g.greg_year);
    mo = int'(g.greg_month);
    dy = int'(g.greg_day);
    // outside the rom: all fields zero, in_range low
    if (yr < ROM_FIRST_YEAR + 1 || yr > ROM_FIRST_YEAR + ROM_YEARS - 1)
      return r;
    // month saturates into 1..12, day is taken as given
    if (mo < 1) mo = 1;
    if (mo > 12) mo = 12;
    idx = yr - ROM_FIRST_YEAR;
    early = (mo < int'(NY_MMDD[idx] / 100)) ||
            (mo == int'(NY_MMDD[idx] / 100) && dy < int'(NY_MMDD[idx] % 100));
    off = dy + DAYS_BEFORE_MON[mo - 1] + 1;
    if (yr % 4 == 0 && mo > 2) off++;
    // before new year: count from the previous lunar new year
    if (early) begin
      idx--;
      off += 365;
      if ((yr - 1) % 4 == 0) off++;
    end
    off -= 31 * (int'(NY_MMDD[idx] / 100) - 1) + int'(NY_MMDD[idx] % 100);
    // walk the months, 29 or 30 days each
    found = 1'b0;
    bits = 0;
    k = 0;
    n = 0;
    while (idx < ROM_YEARS && !found) begin
      bits = MONTH_BITS[idx];
      k = (bits < 4095) ? 11 : 12;
      n = k;
      while (n >= 0 && !found) begin
        span = 29 + int'((bits >> n) & 1);
        if (off <= span) begin
          found = 1'b1;
        end else begin
          off -= span;
          n--;
        end
      end
      if (!found) idx++;
    end
    // walking past the last rom year gives an all-zero result
    if (!found)
      return r;
    pos = k - n + 1;
    mon = pos;
    // thirteen-month year: months after the repeat shift down by one
    if (k == 12) begin
      lm = int'(bits / 65536);
      if (pos == lm + 1) begin
        mon = lm;
        r.leap_month = 1'b1;
      end else if (pos > lm + 1) begin
        mon = pos - 1;
      end
    end
    r.lunar_year  = YEAR_W'(ROM_FIRST_YEAR + idx);
    r.lunar_month = MON_W'(mon);
    r.lunar_day   = DAY_W'(off);
    r.in_range    = 1'b1;
    return r;
  endfunction

  function automatic date_case_t pred_row(input int y, input int m, input int d);
    date_case_t c;
    c = '0;
    c.date.greg_year  = YEAR_W'(y);
    c.date.greg_month = MON_W'(m);
    c.date.greg_day   = DAY_W'(d);
    return c;
  endfunction

  function automatic date_case_t fixed_row(input int y, input int m, input int d,
                                           input int ly, input int lmo, input int lp,
                                           input int ld, input int ok);
    date_case_t c;
    c = pred_row(y, m, d);
    c.typed            = 1'b1;
    c.want.lunar_year  = YEAR_W'(ly);
    c.want.lunar_month = MON_W'(lmo);
    c.want.leap_month  = 1'(lp);
    c.want.lunar_day   = DAY_W'(ld);
    c.want.in_range    = 1'(ok);
    return c;
  endfunction

  // directed dates: range edges, saturation, odd days, new year, leap months
  date_case_t directed [DIRECTED_N] = '{
    fixed_row(1968,  6, 15,    0, 0, 0, 0, 0),  // year just below the table
    fixed_row(2041,  1,  1,    0, 0, 0, 0, 0),  // year just above
    fixed_row(   0,  0,  0,    0, 0, 0, 0, 0),  // all fields zero
    fixed_row(2047, 15, 31,    0, 0, 0, 0, 0),  // all fields at max
    fixed_row(1969,  2, 17, 1969, 1, 0, 1, 1),  // first lunar new year in range
    fixed_row(2000,  2,  5, 2000, 1, 0, 1, 1),
    fixed_row(2040,  2, 12, 2040, 1, 0, 1, 1),  // last lunar new year
    pred_row(1969,  1,  1),                     // earliest date, previous lunar year
    pred_row(2040, 12, 31),                     // latest date
    pred_row(1969,  0,  0),                     // month and day both zero
    pred_row(2000,  0, 15),                     // month zero saturates up
    pred_row(2000, 13, 10),                     // month above twelve saturates down
    pred_row(2010, 15, 31),
    pred_row(2001,  3,  0),                     // day zero is end of previous month
    pred_row(2004,  2, 31),                     // day past month end, leap year
    pred_row(2003,  2, 30),                     // day past month end, common year
    pred_row(2023,  1, 21),                     // lunar new year's eve
    pred_row(2023,  4,  1),                     // inside a repeated month
    pred_row(2020,  6,  1),
    pred_row(2000,  2, 29),
    pred_row(1999, 12, 31),
    pred_row(2033, 12, 31),                     // repeated eleventh month
    pred_row(2034,  1, 15),
    pred_row(2040,  1, 31)                      // before the last new year
  };

  // mostly legal dates, some with odd month or day, some with any year
  function automatic g2l_pkg::g2l_in_t random_date();
    g2l_pkg::g2l_in_t g;
    int sel, y, m, dim;
    sel = int'($urandom_range(99));
    if (sel < 80) begin
      y = ($urandom_range(9) == 0) ? (($urandom_range(1) == 0) ? 1969 : 2040)
                                   : int'($urandom_range(2040, 1969));
      m = int'($urandom_range(12, 1));
      case (m)
        2:           dim = (y % 4 == 0) ? 29 : 28;
        4, 6, 9, 11: dim = 30;
        default:     dim = 31;
      endcase
      g.greg_year  = YEAR_W'(y);
      g.greg_month = MON_W'(m);
      g.greg_day   = DAY_W'($urandom_range(dim, 1));
    end else if (sel < 92) begin
      g.greg_year  = YEAR_W'($urandom_range(2040, 1969));
      g.greg_month = MON_W'($urandom_range(15, 0));
      g.greg_day   = DAY_W'($urandom_range(31, 0));
    end else begin
      g.greg_year  = YEAR_W'($urandom_range(2047, 0));
      g.greg_month = MON_W'($urandom_range(15, 0));
      g.greg_day   = DAY_W'($urandom_range(31, 0));
    end
    return g;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatches++;
    if (mismatches <= 100)
      $display("mismatch at result %0d: %s got %0d want %0d",
               results_seen, what, got, want);
  endtask

  // offer one date from a falling edge, hold it until the transfer,
  // return at the next falling edge with valid still high
  task automatic send_date(input g2l_pkg::g2l_in_t d, input g2l_pkg::g2l_out_t want);
    while (int'($urandom_range(99)) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= d;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    lunar_due_q.push_back(want);
    @(negedge clk);
  endtask

  task automatic send_random(input int count);
    g2l_pkg::g2l_in_t d;
    repeat (count) begin
      d = random_date();
      send_date(d, lunar_date_of(d));
    end
  endtask

  // receiver: random stalls, plus one long hold-off once armed
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_armed && !hold_done) begin
        hold_done = 1'b1;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= (int'($urandom_range(99)) >= rcv_idle_pct);
      end
    end
  end

  // result checker, one transfer at a time against the oldest prediction
  always @(posedge clk) begin
    g2l_pkg::g2l_out_t want;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (lunar_due_q.size() == 0) begin
        report_mismatch("result with nothing pending", int'(out_data), 0);
      end else begin
        want = lunar_due_q.pop_front();
        if (out_data.lunar_year !== want.lunar_year)
          report_mismatch("lunar_year", int'(out_data.lunar_year),
                          int'(want.lunar_year));
        if (out_data.lunar_month !== want.lunar_month)
          report_mismatch("lunar_month", int'(out_data.lunar_month),
                          int'(want.lunar_month));
        if (out_data.leap_month !== want.leap_month)
          report_mismatch("leap_month", int'(out_data.leap_month),
                          int'(want.leap_month));
        if (out_data.lunar_day !== want.lunar_day)
          report_mismatch("lunar_day", int'(out_data.lunar_day),
                          int'(want.lunar_day));
        if (out_data.in_range !== want.in_range)
          report_mismatch("in_range", int'(out_data.in_range),
                          int'(want.in_range));
      end
    end
  end

  // stimulus and end of run
  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_data       = '0;
    send_idle_pct = 37;
    rcv_idle_pct  = 55;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // phase one: sender idles 37 percent, receiver 55 percent
    foreach (directed[i]) begin
      if (directed[i].typed)
        send_date(directed[i].date, directed[i].want);
      else
        send_date(directed[i].date, lunar_date_of(directed[i].date));
    end
    send_random(125);

    // phase two: the other way round
    send_idle_pct = 55;
    rcv_idle_pct  = 37;
    send_random(125);

    // phase three: no idling, one long receiver hold-off to back up the input
    send_idle_pct = 0;
    rcv_idle_pct  = 0;
    hold_armed    = 1'b1;
    send_random(130);
    in_valid <= 1'b0;

    while (lunar_due_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatches == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

  // run limit, far beyond the slowest correct run
  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
